### rtl/core/rprt_pkg.sv
// ----------------------------------------------------------------------------
// rprt_pkg
// shared types and constants of the rf remote pulse transmitter core
// ----------------------------------------------------------------------------
package rprt_pkg;

   localparam int IdBitsDefault  = 26;
   localparam int DevIdWidth     = 26;
   localparam int TicksWidth     = 16;
   localparam int CsrIndexWidth  = 3;
   localparam int SectionWidth   = 3;
   localparam int ButtonWidth    = 2;
   localparam int RepeatWidth    = 8;
   localparam int CommandWidth   = 32;

   localparam logic [CsrIndexWidth-1:0] CsrHighTicks      = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CsrZeroLowTicks   = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CsrOneLowTicks    = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CsrSyncLowTicks   = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CsrFStartLowTicks = 3'd4;
   localparam logic [CsrIndexWidth-1:0] CsrFEndLowTicks   = 3'd5;

   localparam logic [TicksWidth-1:0] HighTicksReset      = 16'd275;
   localparam logic [TicksWidth-1:0] ZeroLowTicksReset   = 16'd275;
   localparam logic [TicksWidth-1:0] OneLowTicksReset    = 16'd1300;
   localparam logic [TicksWidth-1:0] SyncLowTicksReset   = 16'd9900;
   localparam logic [TicksWidth-1:0] FStartLowTicksReset = 16'd2675;
   localparam logic [TicksWidth-1:0] FEndLowTicksReset   = 16'd2675;

   localparam logic [SectionWidth-1:0] SectionGroup = 3'd4;
   localparam logic                    OpTick       = 1'b0;
   localparam logic                    OpStart      = 1'b1;

   typedef struct packed {
      logic [TicksWidth-1:0] high_ticks;
      logic [TicksWidth-1:0] zero_low_ticks;
      logic [TicksWidth-1:0] one_low_ticks;
      logic [TicksWidth-1:0] sync_low_ticks;
      logic [TicksWidth-1:0] frame_start_low_ticks;
      logic [TicksWidth-1:0] frame_end_low_ticks;
   } timing_type;

   typedef struct packed {
      logic line_level;
      logic busy_res;
      logic rejected;
   } result_type;

endpackage

### rtl/core/rprt_csr.sv
// ----------------------------------------------------------------------------
// rprt_csr
// timing register file, written through the csr channel
// ----------------------------------------------------------------------------
module rprt_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [rprt_pkg::CsrIndexWidth-1:0]  csr_index,
   input  logic [rprt_pkg::TicksWidth-1:0]     csr_data,
   output rprt_pkg::timing_type                timing
);
   import rprt_pkg::*;

   timing_type timing_ff;
   timing_type timing_in;

   assign csr_ready = 1'b1;
   assign timing    = timing_ff;

   always_comb begin
      timing_in = timing_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CsrHighTicks:      timing_in.high_ticks            = csr_data;
            CsrZeroLowTicks:   timing_in.zero_low_ticks        = csr_data;
            CsrOneLowTicks:    timing_in.one_low_ticks         = csr_data;
            CsrSyncLowTicks:   timing_in.sync_low_ticks        = csr_data;
            CsrFStartLowTicks: timing_in.frame_start_low_ticks = csr_data;
            CsrFEndLowTicks:   timing_in.frame_end_low_ticks   = csr_data;
            default:           timing_in = timing_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timing_ff.high_ticks            <= HighTicksReset;
         timing_ff.zero_low_ticks        <= ZeroLowTicksReset;
         timing_ff.one_low_ticks         <= OneLowTicksReset;
         timing_ff.sync_low_ticks        <= SyncLowTicksReset;
         timing_ff.frame_start_low_ticks <= FStartLowTicksReset;
         timing_ff.frame_end_low_ticks   <= FEndLowTicksReset;
      end else begin
         timing_ff <= timing_in;
      end
   end

endmodule

### rtl/core/rprt_sequencer.sv
// ----------------------------------------------------------------------------
// rprt_sequencer
// symbol sequencer: command build, tick counting and phase control
// ----------------------------------------------------------------------------
module rprt_sequencer #(
   parameter int ID_BITS = rprt_pkg::IdBitsDefault
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               accept,
   input  logic                               operation,
   input  logic [rprt_pkg::DevIdWidth-1:0]    device_id,
   input  logic [rprt_pkg::SectionWidth-1:0]  section_code,
   input  logic [rprt_pkg::ButtonWidth-1:0]   button_index,
   input  logic                               switch_on,
   input  logic [rprt_pkg::RepeatWidth-1:0]   repeat_count,
   input  rprt_pkg::timing_type               timing,
   output rprt_pkg::result_type               result
);
   import rprt_pkg::*;

   localparam logic [DevIdWidth-1:0] IdMask = DevIdWidth'((64'd1 << ID_BITS) - 64'd1);

   typedef enum logic [4:0] {
      PhIdle   = 5'b00001,
      PhSync   = 5'b00010,
      PhFStart = 5'b00100,
      PhData   = 5'b01000,
      PhFEnd   = 5'b10000
   } phase_type;

   phase_type                phase_ff,   phase_in;
   logic [TicksWidth-1:0]    tick_ff,    tick_in;
   logic [5:0]               index_ff,   index_in;
   logic [RepeatWidth-1:0]   repeats_ff, repeats_in;
   logic [CommandWidth-1:0]  command_ff, command_in;
   logic                     level_ff,   level_in;

   logic [TicksWidth-1:0]    tick_next;
   logic [TicksWidth-1:0]    low_ticks;
   logic [RepeatWidth-1:0]   repeats_dec;
   logic                     data_bit;
   logic                     data_symbol;
   logic                     end_high;
   logic                     end_low;
   logic                     group_cmd;
   logic [DevIdWidth-1:0]    id_masked;

   assign tick_next   = tick_ff + TicksWidth'(1);
   assign repeats_dec = repeats_ff - RepeatWidth'(1);
   assign data_bit    = command_ff[~index_ff[5:1]];
   assign data_symbol = index_ff[0] ? ~data_bit : data_bit;
   assign end_high    = (tick_next == '0) || (tick_next >= timing.high_ticks);
   assign end_low     = (tick_next == '0) || (tick_next >= low_ticks);
   assign group_cmd   = (section_code == SectionGroup);
   assign id_masked   = device_id & IdMask;

   always_comb begin
      unique case (phase_ff)
         PhSync:   low_ticks = timing.sync_low_ticks;
         PhFStart: low_ticks = timing.frame_start_low_ticks;
         PhData:   low_ticks = data_symbol ? timing.one_low_ticks : timing.zero_low_ticks;
         default:  low_ticks = timing.frame_end_low_ticks;
      endcase
   end

   always_comb begin
      phase_in   = phase_ff;
      tick_in    = tick_ff;
      index_in   = index_ff;
      repeats_in = repeats_ff;
      command_in = command_ff;
      level_in   = level_ff;
      result     = '0;
      if (accept) begin
         if (operation == OpStart) begin
            if (phase_ff != PhIdle) begin
               result.rejected   = 1'b1;
               result.line_level = level_ff;
               result.busy_res   = 1'b1;
            end else begin
               command_in = {id_masked, group_cmd, switch_on,
                             group_cmd ? 2'b00 : section_code[1:0],
                             group_cmd ? 2'b00 : button_index};
               repeats_in = repeat_count;
               phase_in   = PhSync;
               tick_in    = '0;
               index_in   = '0;
               level_in   = 1'b1;
               result.busy_res = 1'b1;
            end
         end else if (phase_ff != PhIdle) begin
            result.line_level = level_ff;
            if (level_ff) begin
               if (end_high) begin
                  level_in = 1'b0;
                  tick_in  = '0;
               end else begin
                  tick_in = tick_next;
               end
            end else if (end_low) begin
               tick_in  = '0;
               level_in = 1'b1;
               unique case (phase_ff)
                  PhSync: begin
                     phase_in = PhFStart;
                  end
                  PhFStart: begin
                     if (repeats_ff == '0) begin
                        phase_in = PhIdle;
                        level_in = 1'b0;
                     end else begin
                        phase_in = PhData;
                        index_in = '0;
                     end
                  end
                  PhData: begin
                     if (index_ff == '1) begin
                        phase_in = PhFEnd;
                        index_in = '0;
                     end else begin
                        index_in = index_ff + 6'd1;
                     end
                  end
                  default: begin
                     repeats_in = repeats_dec;
                     if (repeats_dec == '0) begin
                        phase_in = PhIdle;
                        level_in = 1'b0;
                     end else begin
                        phase_in = PhData;
                        index_in = '0;
                     end
                  end
               endcase
            end else begin
               tick_in = tick_next;
            end
            result.busy_res = (phase_in != PhIdle);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PhIdle;
         tick_ff    <= '0;
         index_ff   <= '0;
         repeats_ff <= '0;
         command_ff <= '0;
         level_ff   <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         tick_ff    <= tick_in;
         index_ff   <= index_in;
         repeats_ff <= repeats_in;
         command_ff <= command_in;
         level_ff   <= level_in;
      end
   end

endmodule

### rtl/core/rprt_out_stage.sv
// ----------------------------------------------------------------------------
// rprt_out_stage
// result register with valid/ready hold toward the rsp channel
// ----------------------------------------------------------------------------
module rprt_out_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  rprt_pkg::result_type  result,
   output logic                  in_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_line_level,
   output logic                  rsp_busy_res,
   output logic                  rsp_rejected
);
   import rprt_pkg::*;

   logic       valid_ff, valid_in;
   result_type data_ff;

   assign in_ready       = !valid_ff || rsp_ready;
   assign rsp_valid      = valid_ff;
   assign rsp_line_level = data_ff.line_level;
   assign rsp_busy_res   = data_ff.busy_res;
   assign rsp_rejected   = data_ff.rejected;

   always_comb begin
      if (accept) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         data_ff <= result;
      end
   end

endmodule

### rtl/core/rf_remote_pulse_transmitter_core.sv
// ----------------------------------------------------------------------------
// rf_remote_pulse_transmitter_core
// ook pulse transmitter for 32-bit remote commands with two-symbol data bits
// ----------------------------------------------------------------------------
// the result of a req transfer is in the rsp register in the cycle after the transfer
// throughput: one req transfer per cycle, as the sequencer updates on each
// accepted request; req_ready drops only while a result waits and rsp_ready is low
// reset: synchronous; clears the sequencer to idle, the line low, the result
// register empty, and loads the timing registers with their default values
module rf_remote_pulse_transmitter_core #(
   parameter int ID_BITS = rprt_pkg::IdBitsDefault
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_operation,
   input  logic [rprt_pkg::DevIdWidth-1:0]    req_device_id,
   input  logic [rprt_pkg::SectionWidth-1:0]  req_section_code,
   input  logic [rprt_pkg::ButtonWidth-1:0]   req_button_index,
   input  logic                               req_switch_on,
   input  logic [rprt_pkg::RepeatWidth-1:0]   req_repeat_count,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_line_level,
   output logic                               rsp_busy_res,
   output logic                               rsp_rejected,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [rprt_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [rprt_pkg::TicksWidth-1:0]    csr_data
);
   import rprt_pkg::*;

   timing_type timing;
   result_type result;
   logic       accept;

   assign accept = req_valid && req_ready;

   rprt_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .timing    (timing)
   );

   rprt_sequencer #(
      .ID_BITS (ID_BITS)
   ) u_sequencer (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .operation    (req_operation),
      .device_id    (req_device_id),
      .section_code (req_section_code),
      .button_index (req_button_index),
      .switch_on    (req_switch_on),
      .repeat_count (req_repeat_count),
      .timing       (timing),
      .result       (result)
   );

   rprt_out_stage u_out_stage (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .result         (result),
      .in_ready       (req_ready),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_line_level (rsp_line_level),
      .rsp_busy_res   (rsp_busy_res),
      .rsp_rejected   (rsp_rejected)
   );

endmodule

### rtl/core/rprt_checker.sv
// ----------------------------------------------------------------------------
// rprt_checker
// port-level checks of the transmitter core, bound to the top level
// ----------------------------------------------------------------------------
module rprt_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_line_level,
   input logic rsp_busy_res,
   input logic rsp_rejected
);

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result register not empty after reset");

   a_transfer_result: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> rsp_valid)
      else $error("req transfer gave no result");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_line_level) && $stable(rsp_busy_res)
          && $stable(rsp_rejected)))
      else $error("stalled result changed");

   a_reject_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_rejected) |-> rsp_busy_res)
      else $error("rejected start without busy");

   a_idle_low: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_busy_res) |-> !rsp_line_level)
      else $error("line high while not busy");

endmodule

bind rf_remote_pulse_transmitter_core rprt_checker u_rprt_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_line_level (rsp_line_level),
   .rsp_busy_res   (rsp_busy_res),
   .rsp_rejected   (rsp_rejected)
);

### tb/tb_rf_remote_pulse_transmitter_core.sv
// ----------------------------------------------------------------------------
// tb_rf_remote_pulse_transmitter_core
// self-checking bench for the remote pulse transmitter: sends tick and start
// requests over the valid/ready channel, tracks the sequencer in a local
// model, and compares every line sample taken on the response channel
// ----------------------------------------------------------------------------
module tb_rf_remote_pulse_transmitter_core;
   import rprt_pkg::*;

   localparam int     RandomItems   = 200;
   localparam int     HoldOffCycles = 200;
   localparam int     LastStretch   = 40;
   localparam int     SettleCycles  = 8;
   localparam int     MaxReported   = 10;
   localparam longint LimitTime     = 400000;

   typedef enum logic [2:0] {
      SeqIdle, SeqSync, SeqFrameStart, SeqData, SeqFrameEnd
   } seq_phase_type;

   typedef struct packed {
      logic                    operation;
      logic [DevIdWidth-1:0]   device_id;
      logic [SectionWidth-1:0] section_code;
      logic [ButtonWidth-1:0]  button_index;
      logic                    switch_on;
      logic [RepeatWidth-1:0]  repeat_count;
   } tx_request_type;

   typedef enum logic [1:0] {RowItem, RowRunOut, RowRetime} row_kind_type;

   typedef struct packed {
      row_kind_type   kind;
      tx_request_type req;
      logic           typed;
      result_type     want;
   } plan_row_type;

   localparam timing_type DirectedTiming =
      '{16'd1, 16'd1, 16'd2, 16'd1, 16'd1, 16'd1};

   logic                     clock            = 1'b0;
   logic                     reset            = 1'b1;
   logic                     req_valid        = 1'b0;
   logic                     req_ready;
   logic                     req_operation    = OpTick;
   logic [DevIdWidth-1:0]    req_device_id    = '0;
   logic [SectionWidth-1:0]  req_section_code = '0;
   logic [ButtonWidth-1:0]   req_button_index = '0;
   logic                     req_switch_on    = 1'b0;
   logic [RepeatWidth-1:0]   req_repeat_count = '0;
   logic                     rsp_valid;
   logic                     rsp_ready        = 1'b0;
   logic                     rsp_line_level;
   logic                     rsp_busy_res;
   logic                     rsp_rejected;
   logic                     csr_valid        = 1'b0;
   logic                     csr_ready;
   logic [CsrIndexWidth-1:0] csr_index        = '0;
   logic [TicksWidth-1:0]    csr_data         = '0;

   // local copy of the sequencer
   timing_type              timing_shadow  = '{HighTicksReset, ZeroLowTicksReset,
                                               OneLowTicksReset, SyncLowTicksReset,
                                               FStartLowTicksReset, FEndLowTicksReset};
   seq_phase_type           seq_phase      = SeqIdle;
   logic [TicksWidth-1:0]   tick_tally     = '0;
   logic [6:0]              symbol_pos     = '0;
   logic [RepeatWidth-1:0]  frames_left    = '0;
   logic [CommandWidth-1:0] command_shadow = '0;
   logic                    line_high      = 1'b0;

   result_type pending_samples [$];
   int         items_sent      = 0;
   int         starts_taken    = 0;
   int         starts_refused  = 0;
   int         sequences_done  = 0;
   int         samples_checked = 0;
   int         mismatches      = 0;
   bit         gaps_on          = 1'b0;
   bit         hold_off_pending = 1'b0;

   rf_remote_pulse_transmitter_core u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_device_id    (req_device_id),
      .req_section_code (req_section_code),
      .req_button_index (req_button_index),
      .req_switch_on    (req_switch_on),
      .req_repeat_count (req_repeat_count),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_line_level   (rsp_line_level),
      .rsp_busy_res     (rsp_busy_res),
      .rsp_rejected     (rsp_rejected),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always #1 clock = ~clock;

   function automatic logic [TicksWidth-1:0] low_ticks_now();
      logic symbol_one;
      case (seq_phase)
         SeqSync:       return timing_shadow.sync_low_ticks;
         SeqFrameStart: return timing_shadow.frame_start_low_ticks;
         SeqData: begin
            symbol_one = command_shadow[5'd31 - symbol_pos[5:1]] ^ symbol_pos[0];
            return symbol_one ? timing_shadow.one_low_ticks : timing_shadow.zero_low_ticks;
         end
         default:       return timing_shadow.frame_end_low_ticks;
      endcase
   endfunction

   function automatic void advance_symbol();
      tick_tally = '0;
      line_high  = 1'b1;
      case (seq_phase)
         SeqSync: seq_phase = SeqFrameStart;
         SeqData: begin
            if (symbol_pos >= 7'd63) begin
               seq_phase  = SeqFrameEnd;
               symbol_pos = '0;
            end else begin
               symbol_pos = symbol_pos + 1'b1;
            end
         end
         default: begin
            if (seq_phase == SeqFrameEnd) frames_left = frames_left - 1'b1;
            if (frames_left == '0) begin
               seq_phase = SeqIdle;
               line_high = 1'b0;
            end else begin
               seq_phase  = SeqData;
               symbol_pos = '0;
            end
         end
      endcase
   endfunction

   function automatic result_type line_sample_step(input tx_request_type req);
      result_type              sample;
      logic [CommandWidth-1:0] word;
      sample = '0;
      if (req.operation == OpStart) begin
         if (seq_phase != SeqIdle) begin
            sample.rejected   = 1'b1;
            sample.line_level = line_high;
            starts_refused++;
         end else begin
            word    = {req.device_id, 6'd0};
            word[4] = req.switch_on;
            if (req.section_code == SectionGroup) begin
               word[5] = 1'b1;
            end else begin
               word[3:2] = req.section_code[1:0];
               word[1:0] = req.button_index;
            end
            command_shadow = word;
            frames_left    = req.repeat_count;
            seq_phase      = SeqSync;
            tick_tally     = '0;
            symbol_pos     = '0;
            line_high      = 1'b1;
            starts_taken++;
         end
      end else if (seq_phase != SeqIdle) begin
         sample.line_level = line_high;
         tick_tally = tick_tally + 1'b1;
         if (line_high) begin
            if (tick_tally == '0 || tick_tally >= timing_shadow.high_ticks) begin
               line_high  = 1'b0;
               tick_tally = '0;
            end
         end else if (tick_tally == '0 || tick_tally >= low_ticks_now()) begin
            advance_symbol();
            if (seq_phase == SeqIdle) sequences_done++;
         end
      end
      sample.busy_res = (seq_phase != SeqIdle);
      return sample;
   endfunction

   function automatic tx_request_type random_request(input logic op, input int repeats);
      tx_request_type req;
      req.operation    = op;
      req.device_id    = DevIdWidth'($urandom());
      req.section_code = SectionWidth'($urandom_range(0, 7));
      req.button_index = ButtonWidth'($urandom_range(0, 3));
      req.switch_on    = 1'($urandom_range(0, 1));
      req.repeat_count = RepeatWidth'(repeats);
      return req;
   endfunction

   function automatic logic [TicksWidth-1:0] random_ticks();
      case ($urandom_range(0, 9))
         0:       return '0;
         1, 2:    return 16'd1;
         9:       return TicksWidth'($urandom_range(5, 12));
         default: return TicksWidth'($urandom_range(2, 4));
      endcase
   endfunction

   function automatic int random_frames();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: return 0;
         9:                return $urandom_range(2, 3);
         default:          return 1;
      endcase
   endfunction

   task automatic push_item(input tx_request_type req, input bit typed = 1'b0,
                            input result_type want = '0);
      result_type predicted;
      if (gaps_on && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_operation    <= req.operation;
      req_device_id    <= req.device_id;
      req_section_code <= req.section_code;
      req_button_index <= req.button_index;
      req_switch_on    <= req.switch_on;
      req_repeat_count <= req.repeat_count;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = line_sample_step(req);
      pending_samples.push_back(typed ? want : predicted);
      items_sent++;
   endtask

   task automatic run_out();
      while (seq_phase != SeqIdle) push_item(random_request(OpTick, $urandom_range(0, 255)));
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_samples.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CsrIndexWidth-1:0] index,
                            input logic [TicksWidth-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (index)
         CsrHighTicks:      timing_shadow.high_ticks            = value;
         CsrZeroLowTicks:   timing_shadow.zero_low_ticks        = value;
         CsrOneLowTicks:    timing_shadow.one_low_ticks         = value;
         CsrSyncLowTicks:   timing_shadow.sync_low_ticks        = value;
         CsrFStartLowTicks: timing_shadow.frame_start_low_ticks = value;
         CsrFEndLowTicks:   timing_shadow.frame_end_low_ticks   = value;
         default: ;
      endcase
   endtask

   // writes back to back, valid stays up for the whole batch
   task automatic program_timing(input timing_type t, input bit poke_unused);
      write_csr(CsrHighTicks,      t.high_ticks);
      write_csr(CsrZeroLowTicks,   t.zero_low_ticks);
      write_csr(CsrOneLowTicks,    t.one_low_ticks);
      write_csr(CsrSyncLowTicks,   t.sync_low_ticks);
      write_csr(CsrFStartLowTicks, t.frame_start_low_ticks);
      write_csr(CsrFEndLowTicks,   t.frame_end_low_ticks);
      if (poke_unused) begin
         write_csr(CsrIndexWidth'($urandom_range(CsrFEndLowTicks + 1,
                                                 (1 << CsrIndexWidth) - 1)),
                   TicksWidth'($urandom()));
      end
      csr_valid <= 1'b0;
   endtask

   always @(posedge clock) begin
      result_type seen;
      result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         seen = {rsp_line_level, rsp_busy_res, rsp_rejected};
         if (pending_samples.size() == 0) begin
            mismatches++;
            if (mismatches <= MaxReported) begin
               $display("unexpected transfer on rsp: line %b busy %b rejected %b",
                        seen.line_level, seen.busy_res, seen.rejected);
            end
         end else begin
            want = pending_samples.pop_front();
            samples_checked++;
            if (seen.line_level !== want.line_level || seen.busy_res !== want.busy_res ||
                seen.rejected !== want.rejected) begin
               mismatches++;
               if (mismatches <= MaxReported) begin
                  $display("sample %0d: line exp %b got %b, busy exp %b got %b, %s%b got %b",
                           samples_checked, want.line_level, seen.line_level,
                           want.busy_res, seen.busy_res, "rejected exp ",
                           want.rejected, seen.rejected);
               end
            end
         end
      end
   end

   initial begin : rsp_side
      @(posedge clock);
      forever begin
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            rsp_ready <= 1'b0;
            for (int n = 0; n < HoldOffCycles; n++) @(posedge clock);
         end else if (gaps_on && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            @(posedge clock);
            repeat ($urandom_range(0, 9)) begin
               if (!hold_off_pending) @(posedge clock);
            end
         end else begin
            rsp_ready <= 1'b1;
            @(posedge clock);
            repeat ($urandom_range(0, 19)) begin
               if (!hold_off_pending) @(posedge clock);
            end
         end
      end
   end

   initial begin : watchdog
      #(LimitTime);
      $display("FAIL rf_remote_pulse_transmitter_core");
      $finish;
   end

   initial begin : stimulus
      plan_row_type plan [22];
      int           random_base;
      bit           hold_done;
      timing_type   t;
      plan = '{
         // reset timing: idle tick, single-frame group command, refused start
         '{RowItem,   '{OpTick,  26'h0000000, 3'd0, 2'd0, 1'b0, 8'd0},   1'b1, 3'b000},
         '{RowItem,   '{OpStart, 26'h3ffffff, SectionGroup, 2'd3, 1'b1, 8'd1}, 1'b1, 3'b010},
         '{RowItem,   '{OpTick,  26'h0000000, 3'd0, 2'd0, 1'b0, 8'd0},   1'b1, 3'b110},
         '{RowItem,   '{OpStart, 26'h0000000, 3'd0, 2'd0, 1'b0, 8'd255}, 1'b1, 3'b111},
         '{RowRetime, '0, 1'b0, 3'b000},
         '{RowRunOut, '0, 1'b0, 3'b000},
         '{RowItem,   '{OpTick,  26'h0000000, 3'd0, 2'd0, 1'b0, 8'd0},   1'b1, 3'b000},
         // zero repeats: sync and frame start only
         '{RowItem,   '{OpStart, 26'h0000000, 3'd0, 2'd0, 1'b0, 8'd0},   1'b1, 3'b010},
         '{RowRunOut, '0, 1'b0, 3'b000},
         '{RowItem,   '{OpStart, 26'h0000000, 3'd0, 2'd0, 1'b0, 8'd0},   1'b0, 3'b000},
         '{RowItem,   '{OpStart, 26'h2aaaaaa, 3'd5, 2'd2, 1'b1, 8'd1},   1'b1, 3'b111},
         '{RowRunOut, '0, 1'b0, 3'b000},
         // section codes other than the group code, also those above it, fold to two bits
         '{RowItem,   '{OpStart, 26'h3555555, 3'd7, 2'd1, 1'b0, 8'd1},   1'b0, 3'b000},
         '{RowRunOut, '0, 1'b0, 3'b000},
         '{RowItem,   '{OpStart, 26'h3ffffff, 3'd3, 2'd3, 1'b1, 8'd0},   1'b1, 3'b010},
         '{RowItem,   '{OpTick,  26'h0000000, 3'd0, 2'd0, 1'b0, 8'd0},   1'b1, 3'b110},
         '{RowRunOut, '0, 1'b0, 3'b000},
         '{RowItem,   '{OpStart, 26'h0000001, 3'd6, 2'd0, 1'b0, 8'd0},   1'b0, 3'b000},
         '{RowRunOut, '0, 1'b0, 3'b000},
         '{RowItem,   '{OpStart, 26'h2000000, 3'd1, 2'd2, 1'b1, 8'd0},   1'b0, 3'b000},
         '{RowRunOut, '0, 1'b0, 3'b000},
         '{RowItem,   '{OpTick,  26'h3ffffff, 3'd7, 2'd3, 1'b1, 8'd255}, 1'b1, 3'b000}
      };
      hold_done = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         case (plan[i].kind)
            RowItem:   push_item(plan[i].req, plan[i].typed, plan[i].want);
            RowRunOut: run_out();
            default: begin
               wait_drained();
               program_timing(DirectedTiming, 1'b1);
            end
         endcase
      end

      // random commands with random timing, refused starts and idle noise
      gaps_on     = 1'b1;
      random_base = items_sent;
      while (items_sent - random_base < RandomItems) begin
         wait_drained();
         t = '{random_ticks(), random_ticks(), random_ticks(),
               random_ticks(), random_ticks(), random_ticks()};
         program_timing(t, $urandom_range(0, 3) == 0);
         if (!hold_done) begin
            hold_off_pending = 1'b1;
            hold_done        = 1'b1;
         end
         repeat ($urandom_range(1, 3)) begin
            repeat ($urandom_range(0, 3)) begin
               push_item(random_request(OpTick, $urandom_range(0, 255)));
            end
            push_item(random_request(OpStart, random_frames()));
            while (seq_phase != SeqIdle) begin
               if ($urandom_range(0, 39) == 0) begin
                  push_item(random_request(OpStart, $urandom_range(0, 255)));
               end else begin
                  push_item(random_request(OpTick, $urandom_range(0, 255)));
               end
            end
         end
      end

      // zero timing everywhere, every part lasts one tick, two frames
      gaps_on = 1'b0;
      wait_drained();
      program_timing('{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0}, 1'b0);
      push_item(random_request(OpStart, 2));
      run_out();

      // widest timing everywhere, long repeat count left running
      wait_drained();
      program_timing('{16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff}, 1'b1);
      push_item(random_request(OpStart, $urandom_range(128, 255)));
      push_item(random_request(OpStart, $urandom_range(0, 255)));
      repeat (LastStretch) push_item(random_request(OpTick, $urandom_range(0, 255)));

      wait_drained();
      repeat (SettleCycles) @(posedge clock);
      $display("covered %0d requests: %0d commands started, %0d refused while busy, %0d %s",
               items_sent, starts_taken, starts_refused, sequences_done,
               "sequences run to completion");
      $display("%0d line samples compared, %0d mismatches", samples_checked, mismatches);
      if (mismatches == 0 && pending_samples.size() == 0) begin
         $display("PASS rf_remote_pulse_transmitter_core");
      end else begin
         $display("FAIL rf_remote_pulse_transmitter_core");
      end
      $finish;
   end

endmodule
